>>> sv/rgb_to_hsv_color_classifier_core_defines.svh
// Assertion macros shared by the color classifier RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef RGB_TO_HSV_COLOR_CLASSIFIER_CORE_DEFINES_SVH
`define RGB_TO_HSV_COLOR_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTHC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rthc_pkg.sv
// Shared types and constants of the RGB to HSV color classifier.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rthc_pkg;

   localparam int DIV_STEPS = 10;

   localparam logic [9:0]  HUE_SECTOR = 10'd960;
   localparam logic [12:0] HUE_BASE_GREEN = 13'd1920;
   localparam logic [12:0] HUE_BASE_BLUE = 13'd3840;
   localparam logic [13:0] HUE_FULL = 14'd5760;

   localparam logic [1:0] CSR_HUE_LOW = 2'd0;
   localparam logic [1:0] CSR_HUE_HIGH = 2'd1;
   localparam logic [1:0] CSR_SAT_MIN = 2'd2;
   localparam logic [1:0] CSR_VAL_MIN = 2'd3;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [17:0] hue_rem;
      logic [16:0] hue_div;
      logic [9:0]  hue_quo;
      logic [15:0] sat_rem;
      logic [16:0] sat_div;
      logic [9:0]  sat_quo;
      logic        hue_neg;
      sector_type  sector;
      logic        grey;
      logic [7:0]  max_chan;
   } div_type;

   typedef struct packed {
      logic [12:0] hue_low;
      logic [12:0] hue_high;
      logic [8:0]  sat_min;
      logic [7:0]  val_min;
   } cfg_type;

endpackage

`default_nettype wire

>>> sv/rgb_to_hsv_color_classifier_core.sv
// Top level of the RGB to HSV color classifier: registers, input stage,
// division cell chain and output stage. Depends on rthc_pkg, rthc_front,
// rthc_cell, rthc_back and the assertion macro header.
`default_nettype none

`include "rgb_to_hsv_color_classifier_core_defines.svh"

// Converts one 8-bit RGB pixel per item into hue (1/16 degree), saturation
// (1/256) and brightness, and flags whether the pixel lies inside the
// programmed window. The block takes one item every cycle unless the result
// side stalls; each item passes through one input stage, a chain of ten
// restoring-division cells that each settle one quotient bit of hue and
// saturation together, and one output register. Every stage stalls on its
// own, so bubbles are squeezed out while the result side waits.
module rgb_to_hsv_color_classifier_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [12:0]      rsp_hue,
   output logic [8:0]       rsp_saturation,
   output logic [7:0]       rsp_brightness,
   output logic             rsp_in_range,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);
   import rthc_pkg::*;

   cfg_type cfg_ff;
   div_type chain_data [DIV_STEPS+1];
   logic    chain_valid [DIV_STEPS+1];
   logic    chain_ready [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_low <= 13'd1920;
         cfg_ff.hue_high <= 13'd2880;
         cfg_ff.sat_min <= 9'd76;
         cfg_ff.val_min <= 8'd127;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HUE_LOW:  cfg_ff.hue_low <= csr_wdata;
            CSR_HUE_HIGH: cfg_ff.hue_high <= csr_wdata;
            CSR_SAT_MIN:  cfg_ff.sat_min <= csr_wdata[8:0];
            CSR_VAL_MIN:  cfg_ff.val_min <= csr_wdata[7:0];
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   rthc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .down_valid (chain_valid[0]),
      .down_ready (chain_ready[0]),
      .down_data  (chain_data[0])
   );

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      rthc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[k]),
         .up_ready   (chain_ready[k]),
         .up_data    (chain_data[k]),
         .down_valid (chain_valid[k+1]),
         .down_ready (chain_ready[k+1]),
         .down_data  (chain_data[k+1])
      );
   end

   rthc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (chain_valid[DIV_STEPS]),
      .up_ready       (chain_ready[DIV_STEPS]),
      .up_data        (chain_data[DIV_STEPS]),
      .cfg            (cfg_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .rsp_in_range   (rsp_in_range)
   );

   `RTHC_ASSERT_IMPL(a_hue_wrapped, clock, reset, rsp_valid, rsp_hue < 13'd5760, "hue not wrapped")
   `RTHC_ASSERT_IMPL(a_sat_bound, clock, reset, rsp_valid, rsp_saturation <= 9'd256, "saturation too large")
   `RTHC_ASSERT_IMPL(a_grey_hue, clock, reset, rsp_valid && rsp_saturation == 9'd0, rsp_hue == 13'd0, "grey item with hue")
   `RTHC_ASSERT_IMPL(a_range_val, clock, reset, rsp_valid && rsp_in_range, rsp_brightness > cfg_ff.val_min, "in_range below value floor")
   `RTHC_ASSERT_NEXT(a_fill, clock, reset, req_valid && req_ready, chain_valid[0], "accepted item lost at input stage")

endmodule

`default_nettype wire

>>> sv/rthc_front.sv
// Input stage: finds max, min and hue sector, and forms both dividends.
// Depends on rthc_pkg.
`default_nettype none

module rthc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            up_valid,
   output logic                 up_ready,
   input  wire logic [7:0]      red,
   input  wire logic [7:0]      green,
   input  wire logic [7:0]      blue,
   output logic                 down_valid,
   input  wire logic            down_ready,
   output rthc_pkg::div_type    down_data
);
   import rthc_pkg::*;

   logic       valid_ff;
   div_type    data_ff;
   div_type    data_in;
   logic [7:0] max_chan;
   logic [7:0] min_chan;
   logic [7:0] delta;
   logic [7:0] diff_a;
   logic [7:0] diff_b;
   logic [8:0] diff;
   logic [7:0] mag;
   sector_type sector;

   always_comb begin
      if (red >= green && red >= blue) begin
         sector = SECTOR_RED;
         max_chan = red;
         diff_a = green;
         diff_b = blue;
      end else if (green >= blue) begin
         sector = SECTOR_GREEN;
         max_chan = green;
         diff_a = blue;
         diff_b = red;
      end else begin
         sector = SECTOR_BLUE;
         max_chan = blue;
         diff_a = red;
         diff_b = green;
      end
      min_chan = red;
      if (green < min_chan) begin
         min_chan = green;
      end
      if (blue < min_chan) begin
         min_chan = blue;
      end
      delta = max_chan - min_chan;
      diff = {1'b0, diff_a} - {1'b0, diff_b};
      mag = diff[8] ? 8'(-diff) : diff[7:0];

      data_in.hue_rem = 18'(mag) * 18'(HUE_SECTOR);
      data_in.hue_div = {delta, 9'b0};
      data_in.hue_quo = '0;
      data_in.sat_rem = {delta, 8'b0};
      data_in.sat_div = {max_chan, 9'b0};
      data_in.sat_quo = '0;
      data_in.hue_neg = diff[8];
      data_in.sector = sector;
      data_in.grey = (delta == 8'd0);
      data_in.max_chan = max_chan;
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data = data_ff;

endmodule

`default_nettype wire

>>> sv/rthc_cell.sv
// One restoring-division cell: settles one quotient bit of hue and saturation.
// Depends on rthc_pkg.
`default_nettype none

module rthc_cell (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            up_valid,
   output logic                 up_ready,
   input  wire rthc_pkg::div_type up_data,
   output logic                 down_valid,
   input  wire logic            down_ready,
   output rthc_pkg::div_type    down_data
);
   import rthc_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic    hue_ge;
   logic    sat_ge;

   always_comb begin
      data_in = up_data;
      hue_ge = up_data.hue_rem >= {1'b0, up_data.hue_div};
      sat_ge = {1'b0, up_data.sat_rem} >= up_data.sat_div;
      if (hue_ge) begin
         data_in.hue_rem = up_data.hue_rem - {1'b0, up_data.hue_div};
      end
      if (sat_ge) begin
         data_in.sat_rem = up_data.sat_rem - up_data.sat_div[15:0];
      end
      data_in.hue_quo = {up_data.hue_quo[8:0], hue_ge};
      data_in.sat_quo = {up_data.sat_quo[8:0], sat_ge};
      data_in.hue_div = {1'b0, up_data.hue_div[16:1]};
      data_in.sat_div = {1'b0, up_data.sat_div[16:1]};
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data = data_ff;

endmodule

`default_nettype wire

>>> sv/rthc_back.sv
// Output stage: places the hue in its sector, wraps it, tests the window
// and holds the result item. Depends on rthc_pkg.
`default_nettype none

module rthc_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            up_valid,
   output logic                 up_ready,
   input  wire rthc_pkg::div_type up_data,
   input  wire rthc_pkg::cfg_type cfg,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [12:0]          rsp_hue,
   output logic [8:0]           rsp_saturation,
   output logic [7:0]           rsp_brightness,
   output logic                 rsp_in_range
);
   import rthc_pkg::*;

   logic        valid_ff;
   logic [12:0] hue_ff;
   logic [8:0]  sat_ff;
   logic [7:0]  bright_ff;
   logic        range_ff;
   logic [12:0] hue_in;
   logic [8:0]  sat_in;
   logic        range_in;
   logic [12:0] base;
   logic [13:0] quo_ext;
   logic [13:0] hue_sum;
   logic [13:0] hue_wrap;

   always_comb begin
      unique case (up_data.sector)
         SECTOR_GREEN: base = HUE_BASE_GREEN;
         SECTOR_BLUE:  base = HUE_BASE_BLUE;
         default:      base = '0;
      endcase
      quo_ext = {4'b0, up_data.hue_quo};
      hue_sum = up_data.hue_neg ? {1'b0, base} - quo_ext : {1'b0, base} + quo_ext;
      hue_wrap = hue_sum[13] ? hue_sum + HUE_FULL : hue_sum;
      if (up_data.grey) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = hue_wrap[12:0];
         sat_in = up_data.sat_quo[8:0];
      end
      range_in = (hue_in > cfg.hue_low) && (hue_in < cfg.hue_high) &&
                 (sat_in > cfg.sat_min) && (up_data.max_chan > cfg.val_min);
   end

   assign up_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         bright_ff <= up_data.max_chan;
         range_ff <= range_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_hue = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;
   assign rsp_in_range = range_ff;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the RGB to HSV color classifier core.
// Drives pixels and threshold windows; checks each result against a directed
// table or an internal pixel converter. Depends on rthc_pkg and the core's RTL.
`timescale 1ns / 1ps

module tb_top;
   import rthc_pkg::*;

   localparam int HUE_SIXTH = 960;
   localparam int HUE_TURN = 5760;
   localparam int PHASES = 8;
   localparam int PIXELS_PER_PHASE = 180;
   localparam int QUIET_LIMIT = 2000;
   localparam int DIRECTED_COUNT = 22;

   typedef struct packed {
      logic [12:0] hue;
      logic [8:0]  saturation;
      logic [7:0]  brightness;
      logic        in_range;
   } hsv_result_type;

   typedef struct packed {
      logic [7:0]     red;
      logic [7:0]     green;
      logic [7:0]     blue;
      logic           known;
      hsv_result_type want;
   } pixel_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_red = 8'd0;
   logic [7:0]  req_green = 8'd0;
   logic [7:0]  req_blue = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [12:0] rsp_hue;
   logic [8:0]  rsp_saturation;
   logic [7:0]  rsp_brightness;
   logic        rsp_in_range;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_HUE_LOW;
   logic [12:0] csr_wdata = 13'd0;

   cfg_type        window_cfg;
   hsv_result_type offered_hsv;
   hsv_result_type pending_hsv[$];
   int             gap_pct = 0;
   int             stall_pct = 0;
   int             stall_left = 0;
   int             quiet_cycles = 0;
   int             mismatch_count = 0;
   int             pixels_sent = 0;
   int             results_seen = 0;
   int             window_count = 1;

   pixel_case_type directed_cases [DIRECTED_COUNT] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{13'd0,    9'd0,   8'd0,   1'b0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{13'd0,    9'd0,   8'd255, 1'b0}},
      '{8'd128, 8'd128, 8'd128, 1'b1, '{13'd0,    9'd0,   8'd128, 1'b0}},
      '{8'd255, 8'd0,   8'd0,   1'b1, '{13'd0,    9'd256, 8'd255, 1'b0}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{13'd1920, 9'd256, 8'd255, 1'b0}},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{13'd3840, 9'd256, 8'd255, 1'b0}},
      '{8'd255, 8'd255, 8'd0,   1'b1, '{13'd960,  9'd256, 8'd255, 1'b0}},
      '{8'd0,   8'd255, 8'd255, 1'b1, '{13'd2880, 9'd256, 8'd255, 1'b0}},
      '{8'd255, 8'd0,   8'd255, 1'b1, '{13'd4800, 9'd256, 8'd255, 1'b0}},
      '{8'd1,   8'd0,   8'd0,   1'b1, '{13'd0,    9'd256, 8'd1,   1'b0}},
      '{8'd255, 8'd0,   8'd1,   1'b0, '0},
      '{8'd255, 8'd254, 8'd254, 1'b0, '0},
      '{8'd254, 8'd255, 8'd255, 1'b0, '0},
      '{8'd0,   8'd200, 8'd100, 1'b0, '0},
      '{8'd100, 8'd200, 8'd50,  1'b0, '0},
      '{8'd200, 8'd10,  8'd200, 1'b0, '0},
      '{8'd10,  8'd200, 8'd200, 1'b0, '0},
      '{8'h55,  8'hAA,  8'h55,  1'b0, '0},
      '{8'hAA,  8'h55,  8'hAA,  1'b0, '0},
      '{8'd255, 8'd128, 8'd0,   1'b0, '0},
      '{8'd1,   8'd1,   8'd0,   1'b0, '0},
      '{8'd0,   8'd1,   8'd1,   1'b0, '0}
   };

   rgb_to_hsv_color_classifier_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .rsp_in_range   (rsp_in_range),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic hsv_result_type hsv_of_pixel(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b,
                                                   input cfg_type win);
      int red, grn, blu, top, bot, span, h, s;
      hsv_result_type res;
      red = int'(r);
      grn = int'(g);
      blu = int'(b);
      top = red;
      bot = red;
      if (grn > top) top = grn;
      if (blu > top) top = blu;
      if (grn < bot) bot = grn;
      if (blu < bot) bot = blu;
      span = top - bot;
      h = 0;
      s = 0;
      if (span > 0) begin
         s = (span * 256) / top;
         if (red == top) begin
            h = (HUE_SIXTH * (grn - blu)) / span;
         end else if (grn == top) begin
            h = 2 * HUE_SIXTH + (HUE_SIXTH * (blu - red)) / span;
         end else begin
            h = 4 * HUE_SIXTH + (HUE_SIXTH * (red - grn)) / span;
         end
         if (h < 0) h += HUE_TURN;
      end
      res.hue = h[12:0];
      res.saturation = s[8:0];
      res.brightness = top[7:0];
      res.in_range = (h > int'(win.hue_low)) && (h < int'(win.hue_high)) &&
                     (s > int'(win.sat_min)) && (top > int'(win.val_min));
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 200) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : check_results
      hsv_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_hsv = {pending_hsv, offered_hsv};
            pixels_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_hsv.size() == 0) begin
               report_mismatch("result with no pixel outstanding");
            end else begin
               want = pending_hsv.pop_front();
               if (rsp_hue !== want.hue)
                  report_mismatch($sformatf("hue got %0d expected %0d", rsp_hue, want.hue));
               if (rsp_saturation !== want.saturation)
                  report_mismatch($sformatf("saturation got %0d expected %0d",
                                            rsp_saturation, want.saturation));
               if (rsp_brightness !== want.brightness)
                  report_mismatch($sformatf("brightness got %0d expected %0d",
                                            rsp_brightness, want.brightness));
               if (rsp_in_range !== want.in_range)
                  report_mismatch($sformatf("in_range got %0b expected %0b",
                                            rsp_in_range, want.in_range));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_pct == 0) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic known, input hsv_result_type want);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      offered_hsv = known ? want : hsv_of_pixel(r, g, b, window_cfg);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                               output logic [7:0] b);
      logic [7:0] hi, lo, ext;
      hi = 8'($urandom);
      lo = 8'($urandom_range(0, hi));
      ext = 8'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            r = hi; g = hi; b = hi;
         end
         1: begin
            r = hi; g = hi; b = lo;
         end
         2: begin
            r = lo; g = hi; b = hi;
         end
         3: begin
            r = hi; g = lo; b = hi;
         end
         4: begin
            r = {{7{ext[0]}}, ext[1]};
            g = {{7{ext[2]}}, ext[3]};
            b = {{7{ext[4]}}, ext[5]};
         end
         5: begin
            r = hi; g = hi ^ 8'd1; b = hi;
         end
         default: begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
         end
      endcase
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [12:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic program_window(input cfg_type win);
      logic [4:0] junk;
      junk = 5'($urandom);
      write_csr(CSR_HUE_LOW, win.hue_low);
      write_csr(CSR_HUE_HIGH, win.hue_high);
      write_csr(CSR_SAT_MIN, {junk[3:0], win.sat_min});
      write_csr(CSR_VAL_MIN, {junk, win.val_min});
      csr_we <= 1'b0;
      window_cfg = win;
      window_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_hsv.size() != 0) @(negedge clock);
   endtask

   initial begin
      cfg_type    win;
      logic [7:0] r, g, b;
      int         lo_hue;
      window_cfg = '{13'd1920, 13'd2880, 9'd76, 8'd127};
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin gap_pct = 20; stall_pct = 10; end
            1: begin gap_pct = 0;  stall_pct = 15; end
            2: begin gap_pct = 25; stall_pct = 0;  end
            3: begin gap_pct = 10; stall_pct = 8;  end
            4: begin gap_pct = 0;  stall_pct = 0;  end
            5: begin gap_pct = 40; stall_pct = 20; end
            6: begin gap_pct = 15; stall_pct = 12; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         if (phase == 0) begin
            foreach (directed_cases[i])
               offer_pixel(directed_cases[i].red, directed_cases[i].green,
                           directed_cases[i].blue, directed_cases[i].known,
                           directed_cases[i].want);
         end else begin
            drain_results();
            lo_hue = $urandom_range(0, 5759);
            case (phase)
               1: win = '{13'd0, 13'd5759, 9'd0, 8'd0};
               2: win = '{13'd5759, 13'd0, 9'd256, 8'd255};
               3: win = '{13'h1FFF, 13'h1FFF, 9'h1FF, 8'hFF};
               4: win = '{13'd0, 13'h1FFF, 9'd0, 8'd0};
               default: begin
                  win.hue_low = 13'(lo_hue);
                  win.hue_high = 13'($urandom_range(lo_hue, 5759));
                  win.sat_min = 9'($urandom_range(0, 256));
                  win.val_min = 8'($urandom_range(0, 255));
               end
            endcase
            program_window(win);
         end
         repeat (PIXELS_PER_PHASE) begin
            random_pixel(r, g, b);
            offer_pixel(r, g, b, 1'b0, '0);
         end
      end
      drain_results();
      repeat (30) @(negedge clock);
      $display("Ran %0d pixels (%0d results checked) through %0d threshold windows,",
               pixels_sent, results_seen, window_count);
      $display("covering grey, tied and extreme pixels and out-of-range window settings.");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
